[design/tsch_pkg.sv]
`timescale 1ns / 1ps
package tsch_pkg;

    // sample width in millivolt codes
    localparam int MV_BITS = 12;
    localparam int VAL_W   = 15;
    localparam int THR_W   = 7;

    // divider geometry: widest dividend is a sample times full scale
    localparam int DW    = MV_BITS + VAL_W;
    localparam int DIV_W = (MV_BITS > 11) ? MV_BITS : 11;
    localparam int CNT_W = $clog2(DW + 1);

    // trimmed endpoints may grow one bit past the raw reading
    localparam int LH_W = MV_BITS + 1;

    localparam int APB_AW = 5;
    localparam int APB_DW = 32;
    localparam int IDX_W  = APB_AW - 2;

    localparam int IN_TW  = ((MV_BITS + 7) / 8) * 8;
    localparam int OUT_TW = ((VAL_W + 1 + 7) / 8) * 8;

    localparam logic [VAL_W-1:0] FULL_SCALE    = '1;
    localparam logic [DIV_W-1:0] FALLBACK_MV   = DIV_W'(1650);
    localparam int               PCT_FULL      = 100;
    localparam int               TRIM_PCT      = 2;
    localparam int               TRIM_KEEP     = PCT_FULL - TRIM_PCT;
    localparam int               MARGIN_PCT    = 15;
    localparam int               HYST_PCT      = 5;
    localparam logic [THR_W-1:0] DEF_THRESHOLD = THR_W'(90);

    // register indexes (byte address / 4)
    localparam logic [IDX_W-1:0] REG_PRESSED = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_IDLE    = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_INVERT  = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_CALVAL  = IDX_W'(3);
    localparam logic [IDX_W-1:0] REG_THRESH  = IDX_W'(4);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_TRIM,
        S_SPAN,
        S_MARGIN,
        S_ACT,
        S_NORM,
        S_FIN
    } t_state;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] len;
        logic [DW-1:0]    dividend;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic          done;
        logic [DW-1:0] quot;
    } t_div_rsp;

endpackage

[design/tsch_div.sv]
`timescale 1ns / 1ps
module tsch_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tsch_pkg::t_div_req i_req,
    output tsch_pkg::t_div_rsp o_rsp
);
    import tsch_pkg::*;

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [DIV_W-1:0] r_rem, n_rem;
    logic [DIV_W-1:0] r_dvs, n_dvs;
    logic [DW-1:0]    r_num, n_num;
    logic [DIV_W:0]   part;
    logic             fits;

    // restoring divide, one quotient bit per cycle; dividend comes in left-aligned
    always_comb begin
        part   = {r_rem, r_num[DW-1]};
        fits   = (part >= {1'b0, r_dvs});
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_num  = r_num;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = i_req.len;
            n_rem  = '0;
            n_dvs  = i_req.divisor;
            n_num  = i_req.dividend;
        end else if (r_busy) begin
            n_rem = fits ? DIV_W'(part - {1'b0, r_dvs}) : part[DIV_W-1:0];
            n_num = {r_num[DW-2:0], fits};
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dvs <= n_dvs;
        r_num <= n_num;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_num;

endmodule

[design/trigger_scaler_with_click_hysteresis_top.sv]
`timescale 1ns / 1ps
// Trigger scaler with click hysteresis. Each input word carries one averaged trigger
// sample in millivolts; each output word returns a trigger position from 0 (released)
// to 32767 (fully pressed) and the latched click flag. With calibration_valid clear the
// sample is scaled against 1650 mV; otherwise the pressed and idle readings set the
// range, trimmed by 2% and narrowed by a 15% margin at each end, and invert_sense flips
// the direction. The click engages at click_threshold_percent of full scale and
// releases below five points less. All divisions share one bit-serial divider that
// retires one quotient bit per clock, and that divider sets the rate: an uncalibrated
// word runs one 27-bit divide, a calibrated word a 19-bit trim, a 16-bit margin
// and a 27-bit normalizing divide in that order; a degenerate range ends early with
// a value of 0. One word is processed at a time, and the next is accepted the cycle
// after the previous result is placed in the output register, even if that result
// has not yet been taken.
// Configuration sits on an APB port, registers at byte addresses 0, 4, 8, 12, 16 in the
// order pressed_mv, idle_mv, invert_sense, calibration_valid, click_threshold_percent;
// write it only while the block is idle. Use one instance per trigger.
module trigger_scaler_with_click_hysteresis_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tsch_pkg::APB_AW-1:0]   paddr,
    input  logic [tsch_pkg::APB_DW-1:0]   pwdata,
    output logic [tsch_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [tsch_pkg::IN_TW-1:0]    s_axis_tdata,   // [11:0] sample_mv
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [tsch_pkg::OUT_TW-1:0]   m_axis_tdata    // [14:0] trigger_value, [15] click
);
    import tsch_pkg::*;

    localparam int TRIM_NW = MV_BITS + 7;   // lo*100+97 or hi*98
    localparam int MARG_NW = MV_BITS + 4;   // span*15
    localparam int DIFF_W  = LH_W + 2;      // signed sample minus active low
    localparam int CMP_W   = VAL_W + THR_W; // click point compare

    // configuration registers
    logic [MV_BITS-1:0] r_pressed;
    logic [MV_BITS-1:0] r_idle;
    logic               r_invert;
    logic               r_cal_valid;
    logic [THR_W-1:0]   r_thresh;

    logic               wr_en;
    logic [IDX_W-1:0]   reg_idx;

    // sequencer and datapath
    t_state             r_state, n_state;
    logic [MV_BITS-1:0] r_sample, n_sample;
    logic [LH_W-1:0]    r_lo, n_lo;
    logic [LH_W-1:0]    r_hi, n_hi;
    logic [LH_W:0]      r_act_lo, n_act_lo;
    logic [DIV_W-1:0]   r_act_span, n_act_span;
    logic               r_neg, n_neg;
    logic [VAL_W-1:0]   r_value, n_value;
    logic               r_click_latched, n_click;
    logic               r_out_valid, n_out_valid;
    logic [VAL_W-1:0]   r_out_value, n_out_value;
    logic               r_out_click, n_out_click;

    t_div_req           div_req;
    t_div_rsp           div_rsp;

    logic [MV_BITS-1:0]       lo_raw, hi_raw;
    logic [TRIM_NW-1:0]       trim_x;
    logic signed [LH_W:0]     span;
    logic                     span_pos;
    logic [MARG_NW-1:0]       marg_x;
    logic [MV_BITS-1:0]       margin;
    logic signed [LH_W+1:0]   act_span;
    logic                     act_pos;
    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]        diff_mag;
    logic [MV_BITS-1:0]       mag;
    logic                     q_big;
    logic [VAL_W-1:0]         q_lo, q_sat, fin_value;
    logic [THR_W-1:0]         thr_c, thr_rel;
    logic                     click_next;

    // value >= floor(32767*p/100) is the same as 100*(value+1) > 32767*p
    function automatic logic ge_point(input logic [VAL_W-1:0] v, input logic [THR_W-1:0] p);
        logic [CMP_W-1:0] lhs;
        logic [CMP_W-1:0] rhs;
        lhs = (CMP_W'(v) + CMP_W'(1)) * CMP_W'(PCT_FULL);
        rhs = CMP_W'(p) * CMP_W'(FULL_SCALE);
        return lhs > rhs;
    endfunction

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[APB_AW-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pressed   <= '0;
            r_idle      <= '0;
            r_invert    <= 1'b0;
            r_cal_valid <= 1'b0;
            r_thresh    <= DEF_THRESHOLD;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_PRESSED: r_pressed   <= pwdata[MV_BITS-1:0];
                REG_IDLE:    r_idle      <= pwdata[MV_BITS-1:0];
                REG_INVERT:  r_invert    <= pwdata[0];
                REG_CALVAL:  r_cal_valid <= pwdata[0];
                REG_THRESH:  r_thresh    <= pwdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_PRESSED: prdata = APB_DW'(r_pressed);
            REG_IDLE:    prdata = APB_DW'(r_idle);
            REG_INVERT:  prdata = APB_DW'(r_invert);
            REG_CALVAL:  prdata = APB_DW'(r_cal_valid);
            REG_THRESH:  prdata = APB_DW'(r_thresh);
            default:     prdata = '0;
        endcase
    end

    // ---------------- shared divider ----------------
    tsch_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // ---------------- per-step arithmetic ----------------
    always_comb begin
        lo_raw = (r_pressed < r_idle) ? r_pressed : r_idle;
        hi_raw = (r_pressed < r_idle) ? r_idle : r_pressed;

        // inverted: ceil(lo*100/98); otherwise floor(hi*98/100)
        if (r_invert) begin
            trim_x = TRIM_NW'(lo_raw) * TRIM_NW'(PCT_FULL) + TRIM_NW'(TRIM_KEEP - 1);
        end else begin
            trim_x = TRIM_NW'(hi_raw) * TRIM_NW'(TRIM_KEEP);
        end

        span     = $signed({1'b0, r_hi}) - $signed({1'b0, r_lo});
        span_pos = !span[LH_W] && (span != '0);
        // span here is positive and no larger than a raw reading
        marg_x   = MARG_NW'(span[MV_BITS-1:0]) * MARG_NW'(MARGIN_PCT);

        margin   = div_rsp.quot[MV_BITS-1:0];
        act_span = $signed({1'b0, span}) - $signed((LH_W+2)'({margin, 1'b0}));
        act_pos  = !act_span[LH_W+1] && (act_span != '0);

        diff     = $signed(DIFF_W'(r_sample)) - $signed(DIFF_W'(r_act_lo));
        diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
        // active low stays below the top reading, so the magnitude fits a sample
        mag      = diff_mag[MV_BITS-1:0];

        // signed truncating divide: magnitude quotient plus sign, then invert and clamp
        q_big = |div_rsp.quot[DW-1:VAL_W];
        q_lo  = div_rsp.quot[VAL_W-1:0];
        q_sat = q_big ? FULL_SCALE : q_lo;
        if (!r_cal_valid) begin
            fin_value = q_sat;
        end else if (!r_invert) begin
            fin_value = r_neg ? '0 : q_sat;
        end else begin
            fin_value = r_neg ? FULL_SCALE : (q_big ? '0 : FULL_SCALE - q_lo);
        end

        // click hysteresis: threshold clamps to 100, release point floors at 0
        thr_c      = (r_thresh > THR_W'(PCT_FULL)) ? THR_W'(PCT_FULL) : r_thresh;
        thr_rel    = (thr_c >= THR_W'(HYST_PCT)) ? thr_c - THR_W'(HYST_PCT) : '0;
        click_next = r_click_latched ? ge_point(r_value, thr_rel) : ge_point(r_value, thr_c);
    end

    // ---------------- sequencer ----------------
    always_comb begin
        n_state     = r_state;
        n_sample    = r_sample;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_act_lo    = r_act_lo;
        n_act_span  = r_act_span;
        n_neg       = r_neg;
        n_value     = r_value;
        n_click     = r_click_latched;
        n_out_valid = r_out_valid & ~m_axis_tready;
        n_out_value = r_out_value;
        n_out_click = r_out_click;
        div_req     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_sample = s_axis_tdata[MV_BITS-1:0];
                    n_state  = S_LOAD;
                end
            end
            S_LOAD: begin
                div_req.start = 1'b1;
                if (r_cal_valid) begin
                    div_req.len      = CNT_W'(TRIM_NW);
                    div_req.dividend = {trim_x, {(DW - TRIM_NW){1'b0}}};
                    div_req.divisor  = r_invert ? DIV_W'(TRIM_KEEP) : DIV_W'(PCT_FULL);
                    n_state          = S_TRIM;
                end else begin
                    // sample * 32767 / 1650
                    div_req.len      = CNT_W'(DW);
                    div_req.dividend = {r_sample, {VAL_W{1'b0}}} - DW'(r_sample);
                    div_req.divisor  = FALLBACK_MV;
                    n_state          = S_NORM;
                end
            end
            S_TRIM: begin
                if (div_rsp.done) begin
                    if (r_invert) begin
                        n_lo = div_rsp.quot[LH_W-1:0];
                        n_hi = LH_W'(hi_raw);
                    end else begin
                        n_lo = LH_W'(lo_raw);
                        n_hi = div_rsp.quot[LH_W-1:0];
                    end
                    n_state = S_SPAN;
                end
            end
            S_SPAN: begin
                if (span_pos) begin
                    div_req.start    = 1'b1;
                    div_req.len      = CNT_W'(MARG_NW);
                    div_req.dividend = {marg_x, {(DW - MARG_NW){1'b0}}};
                    div_req.divisor  = DIV_W'(PCT_FULL);
                    n_state          = S_MARGIN;
                end else begin
                    n_value = '0;
                    n_state = S_FIN;
                end
            end
            S_MARGIN: begin
                if (div_rsp.done) begin
                    if (act_pos) begin
                        n_act_lo   = (LH_W+1)'(r_lo) + (LH_W+1)'(margin);
                        n_act_span = act_span[DIV_W-1:0];
                        n_state    = S_ACT;
                    end else begin
                        n_value = '0;
                        n_state = S_FIN;
                    end
                end
            end
            S_ACT: begin
                // |sample - act_lo| * 32767 / act_span
                div_req.start    = 1'b1;
                div_req.len      = CNT_W'(DW);
                div_req.dividend = {mag, {VAL_W{1'b0}}} - DW'(mag);
                div_req.divisor  = r_act_span;
                n_neg            = diff[DIFF_W-1];
                n_state          = S_NORM;
            end
            S_NORM: begin
                if (div_rsp.done) begin
                    n_value = fin_value;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // hold until the output register is free, then update the click latch
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_value = r_value;
                    n_out_click = click_next;
                    n_click     = click_next;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_click_latched <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state         <= n_state;
            r_click_latched <= n_click;
            r_out_valid     <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sample    <= n_sample;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_act_lo    <= n_act_lo;
        r_act_span  <= n_act_span;
        r_neg       <= n_neg;
        r_value     <= n_value;
        r_out_value <= n_out_value;
        r_out_click <= n_out_click;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TW'({r_out_click, r_out_value});

    // ---------------- checks ----------------
    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_FIN)
        else $error("output word loaded outside the finish step");

    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_TRIM || r_state == S_MARGIN || r_state == S_NORM))
        else $error("divider finished while the sequencer was not waiting");

    a_click_only_at_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_FIN) |=> $stable(r_click_latched))
        else $error("click latch changed without a finished word");

    a_trim_needs_cal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TRIM) |-> r_cal_valid)
        else $error("trim divide started without calibration");

endmodule
